// File: rtl/core/fem_stabilization_tau_core_defines.svh
// Assertion macros used by the core top file.
`ifndef FEM_STABILIZATION_TAU_CORE_DEFINES_SVH
`define FEM_STABILIZATION_TAU_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain clocked property, disabled while reset is asserted.
`define FST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// The consequence must hold in the cycle after the antecedent.
`define FST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define FST_ASSERT(lbl, clk, rstn, prop, msg)
`define FST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/core/fst_pkg.sv
package fst_pkg;

  // Field and word widths.
  localparam int unsigned F32_W       = 31;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 64;

  // Unpacked binary64 working format.
  localparam int unsigned MAN_W = 53;
  localparam int unsigned EXP_W = 13;

  // Arithmetic unit depths.
  localparam int unsigned MUL_LAT    = 4;
  localparam int unsigned DIV_QBITS  = 54;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = DIV_QBITS / DIV_STEPS;
  localparam int unsigned DIV_LAT    = DIV_STAGES + 2;

  // A nonnegative value: flags for the special cases, else mn/2^52 * 2^ex.
  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic signed [EXP_W-1:0] ex;
    logic [MAN_W-1:0]        mn;
  } fp_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_RE_SMALL  = 2'd2
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_VEL_MIN   = 2'd0,
    REG_VEL_MAX   = 2'd1,
    REG_VISCOSITY = 2'd2,
    REG_TIME_STEP = 2'd3
  } reg_idx_e;

  localparam logic [F32_W-1:0] VEL_MIN_RST   = 31'h3A83126F;
  localparam logic [F32_W-1:0] VEL_MAX_RST   = 31'h3F800000;
  localparam logic [F32_W-1:0] VISCOSITY_RST = 31'h3F800000;
  localparam logic [F32_W-1:0] TIME_STEP_RST = 31'h3F800000;

  // Constants in the working format, rounded as binary64.
  localparam fp_t FP_ONE     = '{1'b0, 1'b0, 1'b0, 13'sd0,   {1'b1, 52'h0000000000000}};
  localparam fp_t FP_THIRD   = '{1'b0, 1'b0, 1'b0, -13'sd2,  {1'b1, 52'h5555555555555}};
  localparam fp_t FP_TWELFTH = '{1'b0, 1'b0, 1'b0, -13'sd4,  {1'b1, 52'h5555555555555}};
  localparam fp_t FP_RE_MIN  = '{1'b0, 1'b0, 1'b0, -13'sd40, {1'b1, 52'h19799812DEA11}};

  // Multiply by a power of two; no overflow occurs in this range.
  function automatic fp_t fp_scale(fp_t a, logic signed [EXP_W-1:0] d);
    fp_t r;
    r    = a;
    r.ex = a.ex + d;
    return r;
  endfunction

  // a > b for nonnegative values, false when either is NaN.
  function automatic logic fp_gt(fp_t a, fp_t b);
    logic r;
    priority if (a.nan || b.nan) r = 1'b0;
    else if (a.zero)             r = 1'b0;
    else if (b.zero)             r = 1'b1;
    else if (b.inf)              r = 1'b0;
    else if (a.inf)              r = 1'b1;
    else r = (a.ex > b.ex) || ((a.ex == b.ex) && (a.mn > b.mn));
    return r;
  endfunction

  // a >= b for nonnegative values, false when either is NaN.
  function automatic logic fp_ge(fp_t a, fp_t b);
    logic r;
    priority if (a.nan || b.nan) r = 1'b0;
    else if (b.zero)             r = 1'b1;
    else if (a.zero)             r = 1'b0;
    else if (a.inf)              r = 1'b1;
    else if (b.inf)              r = 1'b0;
    else r = (a.ex > b.ex) || ((a.ex == b.ex) && (a.mn >= b.mn));
    return r;
  endfunction

endpackage

// File: rtl/core/fst_mul.sv
module fst_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  fst_pkg::fp_t a_i,
  input  fst_pkg::fp_t b_i,
  output fst_pkg::fp_t p_o
);
  import fst_pkg::*;

  localparam int unsigned LO_W = 26;
  localparam int unsigned HI_W = MAN_W - LO_W;
  localparam int unsigned FULL_W = 2 * MAN_W;

  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic signed [EXP_W-1:0] ex;
  } mfl_t;

  mfl_t                     fl1_q, fl2_q, fl3_q;
  logic [2*HI_W-1:0]        hh1_q, hh2_q;
  logic [HI_W+LO_W-1:0]     hl1_q, lh1_q;
  logic [2*LO_W-1:0]        ll1_q, ll2_q;
  logic [HI_W+LO_W:0]       mid2_q;
  logic [FULL_W-1:0]        full3_q;
  fp_t                      p_q, p_d;
  mfl_t                     fl1_d;

  // Special values and the exponent sum.
  always_comb begin
    fl1_d.nan  = a_i.nan | b_i.nan | (a_i.zero & b_i.inf) | (a_i.inf & b_i.zero);
    fl1_d.inf  = !fl1_d.nan & (a_i.inf | b_i.inf);
    fl1_d.zero = !fl1_d.nan & !fl1_d.inf & (a_i.zero | b_i.zero);
    fl1_d.ex   = a_i.ex + b_i.ex;
  end

  // Stage one: four partial products; stage two: middle sum; stage three: full sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl1_q   <= fl1_d;
      hh1_q   <= a_i.mn[MAN_W-1:LO_W] * b_i.mn[MAN_W-1:LO_W];
      hl1_q   <= a_i.mn[MAN_W-1:LO_W] * b_i.mn[LO_W-1:0];
      lh1_q   <= a_i.mn[LO_W-1:0] * b_i.mn[MAN_W-1:LO_W];
      ll1_q   <= a_i.mn[LO_W-1:0] * b_i.mn[LO_W-1:0];
      fl2_q   <= fl1_q;
      hh2_q   <= hh1_q;
      ll2_q   <= ll1_q;
      mid2_q  <= {1'b0, hl1_q} + {1'b0, lh1_q};
      fl3_q   <= fl2_q;
      full3_q <= {hh2_q, {(2*LO_W){1'b0}}}
               + {{(FULL_W-HI_W-2*LO_W-1){1'b0}}, mid2_q, {LO_W{1'b0}}}
               + {{(FULL_W-2*LO_W){1'b0}}, ll2_q};
      p_q     <= p_d;
    end
  end

  // Stage four: normalise by at most one place and round to nearest even.
  always_comb begin
    logic             top;
    logic [MAN_W-1:0] man;
    logic             g;
    logic             s;
    logic             inc;
    logic [MAN_W:0]   sum;
    top = full3_q[FULL_W-1];
    man = top ? full3_q[FULL_W-1:MAN_W] : full3_q[FULL_W-2:MAN_W-1];
    g   = top ? full3_q[MAN_W-1] : full3_q[MAN_W-2];
    s   = top ? |full3_q[MAN_W-2:0] : |full3_q[MAN_W-3:0];
    inc = g & (s | man[0]);
    sum = {1'b0, man} + {{MAN_W{1'b0}}, inc};
    p_d.nan  = fl3_q.nan;
    p_d.inf  = fl3_q.inf;
    p_d.zero = fl3_q.zero;
    p_d.ex   = fl3_q.ex + {{(EXP_W-1){1'b0}}, top} + {{(EXP_W-1){1'b0}}, sum[MAN_W]};
    p_d.mn   = sum[MAN_W] ? {1'b1, {(MAN_W-1){1'b0}}} : sum[MAN_W-1:0];
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/fst_div.sv
module fst_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  fst_pkg::fp_t n_i,
  input  fst_pkg::fp_t d_i,
  output fst_pkg::fp_t q_o
);
  import fst_pkg::*;

  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic signed [EXP_W-1:0] ex;
  } dfl_t;

  dfl_t                 fl_q [DIV_STAGES+1];
  logic [DIV_QBITS-1:0] r_q  [DIV_STAGES+1];
  logic [DIV_QBITS-1:0] qb_q [DIV_STAGES+1];
  logic [MAN_W-1:0]     d_q  [DIV_STAGES+1];
  dfl_t                 fl0_d;
  logic                 lt;
  fp_t                  q_q, q_d;

  // Specials, and alignment so that the quotient lies in [1, 2).
  always_comb begin
    lt         = n_i.mn < d_i.mn;
    fl0_d.nan  = n_i.nan | d_i.nan | (n_i.zero & d_i.zero) | (n_i.inf & d_i.inf);
    fl0_d.inf  = !fl0_d.nan & (n_i.inf | d_i.zero);
    fl0_d.zero = !fl0_d.nan & !fl0_d.inf & (n_i.zero | d_i.inf);
    fl0_d.ex   = n_i.ex - d_i.ex - {{(EXP_W-1){1'b0}}, lt};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0] <= fl0_d;
      r_q[0]  <= lt ? {n_i.mn, 1'b0} : {1'b0, n_i.mn};
      qb_q[0] <= '0;
      d_q[0]  <= d_i.mn;
    end
  end

  // Restoring division, a fixed number of quotient bits per stage.
  for (genvar gi = 1; gi <= DIV_STAGES; gi++) begin : g_step
    logic [DIV_QBITS-1:0] r_n;
    logic [DIV_QBITS-1:0] q_n;

    always_comb begin
      r_n = r_q[gi-1];
      q_n = qb_q[gi-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (r_n >= {1'b0, d_q[gi-1]}) begin
          q_n = {q_n[DIV_QBITS-2:0], 1'b1};
          r_n = r_n - {1'b0, d_q[gi-1]};
        end else begin
          q_n = {q_n[DIV_QBITS-2:0], 1'b0};
        end
        r_n = {r_n[DIV_QBITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[gi] <= fl_q[gi-1];
        r_q[gi]  <= r_n;
        qb_q[gi] <= q_n;
        d_q[gi]  <= d_q[gi-1];
      end
    end
  end

  // Round the quotient to nearest even; the remainder gives the sticky bit.
  always_comb begin
    logic [MAN_W-1:0] man;
    logic             inc;
    logic [MAN_W:0]   sum;
    man = qb_q[DIV_STAGES][DIV_QBITS-1:1];
    inc = qb_q[DIV_STAGES][0] & ((r_q[DIV_STAGES] != '0) | man[0]);
    sum = {1'b0, man} + {{MAN_W{1'b0}}, inc};
    q_d.nan  = fl_q[DIV_STAGES].nan;
    q_d.inf  = fl_q[DIV_STAGES].inf;
    q_d.zero = fl_q[DIV_STAGES].zero;
    q_d.ex   = fl_q[DIV_STAGES].ex + {{(EXP_W-1){1'b0}}, sum[MAN_W]};
    q_d.mn   = sum[MAN_W] ? {1'b1, {(MAN_W-1){1'b0}}} : sum[MAN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: rtl/core/fem_stabilization_tau_core.sv
// Stabilisation tau unit: takes one integration point per word (velocity norm, element
// size, shape-function count) and returns the momentum tau, the continuity tau and a
// status code, with binary64 arithmetic rounded once to binary32 at the end. A new word
// is taken in every cycle unless the output register is full; the pipeline holds three
// chained four-stage multipliers and a 29-stage divider producing two quotient bits per
// stage. A full output register stalls the whole pipeline until the word is taken.
// Registers are written over the configuration channel, which is always ready, and
// should only change while no word is in flight.
`include "fem_stabilization_tau_core_defines.svh"

module fem_stabilization_tau_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fst_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [fst_pkg::F32_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // vel_norm [30:0], elem_size [61:31], shape_fn_count [65:62], zero padding above.
  input  logic [fst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // momentum_tau [30:0], continuity_tau [61:31], zero padding above.
  output logic [fst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status [1:0].
  output logic [fst_pkg::STATUS_W-1:0]        m_axis_tuser
);
  import fst_pkg::*;

  localparam int unsigned LM    = MUL_LAT;
  localparam int unsigned LD    = DIV_LAT;
  localparam int unsigned I_D   = 2 * LM + LD;
  localparam int unsigned I_Z   = I_D + 1;
  localparam int unsigned I_OUT = I_Z + LM + 1;

  // Widen a binary32 pattern exactly, normalising subnormals.
  function automatic fp_t f32_unpack(logic [F32_W-1:0] p);
    fp_t         r;
    logic [7:0]  e;
    logic [22:0] f;
    logic [22:0] fs;
    logic [4:0]  lz;
    logic        found;
    e     = p[30:23];
    f     = p[22:0];
    lz    = '0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && f[i]) begin
        lz    = 5'(22 - i);
        found = 1'b1;
      end
    end
    fs     = f << lz;
    r.nan  = (e == 8'hFF) && (f != '0);
    r.inf  = (e == 8'hFF) && (f == '0);
    r.zero = (e == 8'h00) && (f == '0);
    if (e == 8'h00) begin
      r.ex = -13'sd127 - $signed({8'd0, lz});
      r.mn = {1'b1, fs[21:0], 30'd0};
    end else begin
      r.ex = $signed({5'd0, e}) - 13'sd127;
      r.mn = {1'b1, f, 29'd0};
    end
    return r;
  endfunction

  // Round to the nearest binary32 pattern, subnormals and overflow included.
  function automatic logic [F32_W-1:0] f32_pack(fp_t a);
    logic [F32_W-1:0]        r;
    logic [7:0]              be;
    logic                    inc;
    logic signed [EXP_W-1:0] sh;
    logic [6:0]              shamt;
    logic [MAN_W+54:0]       wide;
    be    = 8'(a.ex + 13'sd127);
    sh    = -13'sd97 - a.ex;
    shamt = (sh > 13'sd107) ? 7'd107 : 7'(sh);
    wide  = {a.mn, 55'd0} >> shamt;
    priority if (a.nan) begin
      r = 31'h7FC00000;
    end else if (a.inf || (a.ex > 13'sd127)) begin
      r = 31'h7F800000;
    end else if (a.zero) begin
      r = '0;
    end else if (a.ex >= -13'sd126) begin
      inc = a.mn[28] & ((|a.mn[27:0]) | a.mn[29]);
      r   = {be, a.mn[51:29]} + {30'd0, inc};
    end else begin
      inc = wide[54] & ((|wide[53:0]) | wide[55]);
      r   = wide[85:55] + {30'd0, inc};
    end
    return r;
  endfunction

  function automatic logic pat_nan(logic [F32_W-1:0] p);
    return (p[30:23] == 8'hFF) && (p[22:0] != '0);
  endfunction

  logic [F32_W-1:0] vel_min_q, vel_max_q, viscosity_q, time_step_q;
  logic             pipe_en;
  logic [I_OUT:0]   vld_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_min_q   <= VEL_MIN_RST;
      vel_max_q   <= VEL_MAX_RST;
      viscosity_q <= VISCOSITY_RST;
      time_step_q <= TIME_STEP_RST;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_VEL_MIN:   vel_min_q   <= cfg_data_i;
        REG_VEL_MAX:   vel_max_q   <= cfg_data_i;
        REG_VISCOSITY: viscosity_q <= cfg_data_i;
        REG_TIME_STEP: time_step_q <= cfg_data_i;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  fp_t nu_fp, dt_fp, den_fp;
  assign nu_fp  = f32_unpack(viscosity_q);
  assign dt_fp  = f32_unpack(time_step_q);
  assign den_fp = fp_scale(nu_fp, 13'sd1);

  // Whole pipeline advances unless the output word is held.
  assign pipe_en       = !vld_q[I_OUT] || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[I_OUT-1:0], s_axis_tvalid};
    end
  end

  // Input stage: clamp the velocity, pick the element factor, unpack.
  logic [F32_W-1:0]   u_pat, h_pat, v_pat;
  logic [COUNT_W-1:0] n_cnt;
  logic               is_lin, is_quad;
  fp_t                v_q, h_q, m_q;
  logic               nbad_q;

  always_comb begin
    u_pat   = s_axis_tdata[30:0];
    h_pat   = s_axis_tdata[61:31];
    n_cnt   = s_axis_tdata[65:62];
    is_lin  = (n_cnt == 4'd3) || (n_cnt == 4'd4);
    is_quad = (n_cnt == 4'd6) || (n_cnt == 4'd8);
    priority if (!pat_nan(u_pat) && !pat_nan(vel_min_q) && (u_pat < vel_min_q)) begin
      v_pat = vel_min_q;
    end else if (!pat_nan(u_pat) && !pat_nan(vel_max_q) && (u_pat > vel_max_q)) begin
      v_pat = vel_max_q;
    end else begin
      v_pat = u_pat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      v_q    <= f32_unpack(v_pat);
      h_q    <= f32_unpack(h_pat);
      m_q    <= is_quad ? FP_TWELFTH : FP_THIRD;
      nbad_q <= !(is_lin || is_quad);
    end
  end

  // First products and h/(2V).
  fp_t mv, vh, mh, tq;

  fst_mul u_mul_mv (.clk_i, .en_i(pipe_en), .a_i(m_q), .b_i(v_q), .p_o(mv));
  fst_mul u_mul_vh (.clk_i, .en_i(pipe_en), .a_i(v_q), .b_i(h_q), .p_o(vh));
  fst_mul u_mul_mh (.clk_i, .en_i(pipe_en), .a_i(m_q), .b_i(h_q), .p_o(mh));
  fst_div u_div_tm (.clk_i, .en_i(pipe_en), .n_i(h_q), .d_i(fp_scale(v_q, 13'sd1)), .q_o(tq));

  // Element size held until the second products.
  fp_t h_dly [LM];
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      h_dly[0] <= h_q;
      for (int i = 1; i < LM; i++) h_dly[i] <= h_dly[i-1];
    end
  end

  fp_t num, mhh, re, bnd;

  fst_mul u_mul_num (.clk_i, .en_i(pipe_en), .a_i(mv), .b_i(h_dly[LM-1]), .p_o(num));
  fst_mul u_mul_mhh (.clk_i, .en_i(pipe_en), .a_i(mh), .b_i(h_dly[LM-1]), .p_o(mhh));

  // Reynolds number and the viscous bound.
  fst_div u_div_re  (.clk_i, .en_i(pipe_en), .n_i(num), .d_i(den_fp), .q_o(re));
  fst_div u_div_bnd (.clk_i, .en_i(pipe_en), .n_i(fp_scale(mhh, -13'sd2)), .d_i(nu_fp),
                     .q_o(bnd));

  // Side values aligned with the divider outputs.
  logic numpos_dly [LD];
  fp_t  tq_dly     [2*LM];
  fp_t  vh_dly     [LM+LD];
  logic nbad_dly   [I_D];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      numpos_dly[0] <= !num.nan && !num.zero;
      for (int i = 1; i < LD; i++) numpos_dly[i] <= numpos_dly[i-1];
      tq_dly[0] <= tq;
      for (int i = 1; i < 2 * LM; i++) tq_dly[i] <= tq_dly[i-1];
      vh_dly[0] <= vh;
      for (int i = 1; i < LM + LD; i++) vh_dly[i] <= vh_dly[i-1];
      nbad_dly[0] <= nbad_q;
      for (int i = 1; i < I_D; i++) nbad_dly[i] <= nbad_dly[i-1];
    end
  end

  // Decision stage: zeta, status and the bounded momentum tau.
  fp_t     zeta_d, tmu_d;
  status_e st_d;
  fp_t     zeta_q, tmu_q, vhz_q;
  status_e st_q;

  always_comb begin
    logic nu_zero;
    nu_zero = 1'b0;
    zeta_d  = FP_ONE;
    st_d    = ST_OK;
    priority if (nbad_dly[I_D-1]) begin
      st_d = ST_BAD_COUNT;
    end else if (!nu_fp.nan && !nu_fp.zero) begin
      priority if (fp_ge(re, FP_RE_MIN) && fp_gt(FP_ONE, re)) begin
        zeta_d = re;
      end else if (fp_ge(re, FP_ONE)) begin
        zeta_d = FP_ONE;
      end else begin
        st_d = ST_RE_SMALL;
      end
    end else if (nu_fp.zero && numpos_dly[LD-1]) begin
      nu_zero = 1'b1;
    end else begin
      st_d = ST_RE_SMALL;
    end
    tmu_d = tq_dly[2*LM-1];
    if (fp_gt(tmu_d, dt_fp)) tmu_d = dt_fp;
    if (!nu_zero && fp_gt(tmu_d, bnd)) tmu_d = bnd;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      zeta_q <= zeta_d;
      tmu_q  <= tmu_d;
      st_q   <= st_d;
      vhz_q  <= vh_dly[LM+LD-1];
    end
  end

  // Continuity tau product, with status and momentum tau alongside.
  fp_t     tc;
  fp_t     tmu_dly [LM];
  status_e st_dly  [LM];

  fst_mul u_mul_tc (.clk_i, .en_i(pipe_en), .a_i(vhz_q), .b_i(zeta_q), .p_o(tc));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tmu_dly[0] <= tmu_q;
      st_dly[0]  <= st_q;
      for (int i = 1; i < LM; i++) begin
        tmu_dly[i] <= tmu_dly[i-1];
        st_dly[i]  <= st_dly[i-1];
      end
    end
  end

  // Output register: round both taus, zero them on any error.
  logic [F32_W-1:0] mom_q, con_q;
  status_e          sto_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sto_q <= st_dly[LM-1];
      if (st_dly[LM-1] == ST_OK) begin
        mom_q <= f32_pack(tmu_dly[LM-1]);
        con_q <= f32_pack(fp_scale(tc, -13'sd1));
      end else begin
        mom_q <= '0;
        con_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = vld_q[I_OUT];
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*F32_W){1'b0}}, con_q, mom_q};
  assign m_axis_tuser  = sto_q;

  `FST_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted word did not enter the pipeline")
  `FST_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !pipe_en, $stable(vld_q), "pipeline moved while stalled")
  `FST_ASSERT(a_err_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0), "error word carries nonzero taus")

endmodule
